// ===== rtl/sti_pkg.sv =====
`default_nettype none

package sti_pkg;

  localparam int unsigned ENTRIES  = 16;
  localparam int unsigned IDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned TICK_W   = 48;
  localparam int unsigned TAG_W    = 32;
  localparam int unsigned PERIOD_W = 16;
  localparam int unsigned PADDR_W  = 3;
  localparam int unsigned PDATA_W  = 32;

  localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};

  // input kinds
  localparam logic KIND_ADD  = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  // result kinds
  localparam logic [1:0] RES_EXPIRY   = 2'd0;
  localparam logic [1:0] RES_STATUS   = 2'd1;
  localparam logic [1:0] RES_ADD_OK   = 2'd2;
  localparam logic [1:0] RES_ADD_FULL = 2'd3;

  // register indexes, taken from paddr[2]
  localparam logic REG_TASK_TAG    = 1'b0;
  localparam logic REG_TASK_PERIOD = 1'b1;

  localparam logic signed [TAG_W-1:0] TASK_TAG_RST    = 32'sh8000_0000;
  localparam logic [PERIOD_W-1:0]     TASK_PERIOD_RST = 16'd2;

  typedef struct packed {
    logic                    kind;
    logic [TICK_W-1:0]       due_time;
    logic signed [TAG_W-1:0] tag;
  } in_t;

  typedef struct packed {
    logic [1:0]              kind_res;
    logic [TICK_W-1:0]       due_time_res;
    logic signed [TAG_W-1:0] tag_res;
    logic                    task_switch;
    logic                    last;
  } out_t;

  typedef enum logic {
    TOK_ADD,
    TOK_SEARCH
  } tok_op_e;

  // token that walks the row of cells, one cell per cycle
  typedef struct packed {
    logic                    act;
    tok_op_e                 op;
    logic                    found;
    logic [TICK_W-1:0]       due;
    logic signed [TAG_W-1:0] tag;
    logic [IDX_W-1:0]        idx;
  } token_t;

  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_CLEAR_DONE,
    CMD_REARM,
    CMD_POP
  } cmd_op_e;

  // broadcast from the controller to every cell
  typedef struct packed {
    cmd_op_e           op;
    logic [IDX_W-1:0]  idx;
    logic [TICK_W-1:0] due;
  } cmd_t;

endpackage

`default_nettype wire

// ===== rtl/sti_cell.sv =====
`default_nettype none

module sti_cell
  import sti_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [IDX_W-1:0]  cell_idx_i,
  input  logic [TICK_W-1:0] tick_i,
  input  cmd_t              cmd_i,
  input  token_t            tok_i,
  output token_t            tok_o
);

  logic                    valid_q, valid_d;
  logic                    done_q, done_d;
  logic [TICK_W-1:0]       due_q, due_d;
  logic signed [TAG_W-1:0] tag_q, tag_d;
  token_t                  tok_q, tok_d;
  logic                    hit;
  logic                    eligible;

  assign hit      = (cmd_i.idx == cell_idx_i);
  assign eligible = valid_q && !done_q && (due_q <= tick_i);

  always_comb begin
    valid_d = valid_q;
    done_d  = done_q;
    due_d   = due_q;
    tag_d   = tag_q;
    tok_d   = tok_i;

    unique case (cmd_i.op)
      CMD_NONE: begin
      end
      CMD_CLEAR_DONE: begin
        done_d = 1'b0;
      end
      CMD_REARM: begin
        if (hit) begin
          due_d  = cmd_i.due;
          done_d = 1'b1;
        end
      end
      CMD_POP: begin
        if (hit) begin
          valid_d = 1'b0;
        end
      end
    endcase

    if (tok_i.act) begin
      if (tok_i.op == TOK_ADD) begin
        // first free slot claims the new timer
        if (!tok_i.found && !valid_q) begin
          valid_d     = 1'b1;
          due_d       = tok_i.due;
          tag_d       = tok_i.tag;
          tok_d.found = 1'b1;
          tok_d.idx   = cell_idx_i;
        end
      end else if (eligible && (!tok_i.found || (due_q < tok_i.due))) begin
        // strictly earlier wins, so ties keep the lower slot
        tok_d.found = 1'b1;
        tok_d.due   = due_q;
        tok_d.tag   = tag_q;
        tok_d.idx   = cell_idx_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      done_q  <= 1'b0;
      tok_q   <= '0;
    end else begin
      valid_q <= valid_d;
      done_q  <= done_d;
      tok_q   <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    due_q <= due_d;
    tag_q <= tag_d;
  end

  assign tok_o = tok_q;

endmodule

`default_nettype wire

// ===== rtl/sti_ctrl.sv =====
`default_nettype none

module sti_ctrl
  import sti_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  in_t                     in_data_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output out_t                    out_data_o,
  input  logic signed [TAG_W-1:0] task_tag_i,
  input  logic [PERIOD_W-1:0]     task_period_i,
  output logic [TICK_W-1:0]       tick_o,
  output token_t                  inj_o,
  input  token_t                  chain_i,
  output cmd_t                    cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } state_e;

  state_e            state_q, state_d;
  logic [TICK_W-1:0] tick_q, tick_d;
  logic              sw_q, sw_d;
  token_t            inj_q, inj_d;
  out_t              res_q, res_d;
  logic              out_valid_q, out_valid_d;
  out_t              out_q, out_d;
  logic              out_free;
  logic [TICK_W:0]   rearm_sum;
  logic [TICK_W-1:0] rearm_due;
  token_t            search_tok;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign rearm_sum  = {1'b0, tick_q} + {{(TICK_W+1-PERIOD_W){1'b0}}, task_period_i};
  assign rearm_due  = rearm_sum[TICK_W] ? TICK_MAX : rearm_sum[TICK_W-1:0];

  always_comb begin
    search_tok       = '0;
    search_tok.act   = 1'b1;
    search_tok.op    = TOK_SEARCH;
  end

  always_comb begin
    state_d     = state_q;
    tick_d      = tick_q;
    sw_d        = sw_q;
    inj_d       = inj_q;
    inj_d.act   = 1'b0;
    res_d       = res_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    cmd_o       = '0;
    cmd_o.op    = CMD_NONE;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_SCAN;
          if (in_data_i.kind == KIND_ADD) begin
            inj_d.act   = 1'b1;
            inj_d.op    = TOK_ADD;
            inj_d.found = 1'b0;
            inj_d.due   = in_data_i.due_time;
            inj_d.tag   = in_data_i.tag;
            inj_d.idx   = '0;
          end else begin
            tick_d   = (tick_q == TICK_MAX) ? tick_q : tick_q + TICK_W'(1);
            sw_d     = 1'b0;
            cmd_o.op = CMD_CLEAR_DONE;
            inj_d    = search_tok;
          end
        end
      end
      ST_SCAN: begin
        if (chain_i.act) begin
          res_d = '0;
          if (chain_i.op == TOK_ADD) begin
            res_d.kind_res = chain_i.found ? RES_ADD_OK : RES_ADD_FULL;
            res_d.last     = 1'b1;
            state_d        = ST_EMIT;
          end else if (chain_i.found && (chain_i.tag == task_tag_i)) begin
            // task timer: re-arm in place and search again
            cmd_o.op  = CMD_REARM;
            cmd_o.idx = chain_i.idx;
            cmd_o.due = rearm_due;
            sw_d      = 1'b1;
            inj_d     = search_tok;
          end else if (chain_i.found) begin
            cmd_o.op           = CMD_POP;
            cmd_o.idx          = chain_i.idx;
            res_d.kind_res     = RES_EXPIRY;
            res_d.due_time_res = chain_i.due;
            res_d.tag_res      = chain_i.tag;
            state_d            = ST_EMIT;
          end else begin
            res_d.kind_res    = RES_STATUS;
            res_d.task_switch = sw_q;
            res_d.last        = 1'b1;
            state_d           = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = res_q;
          if (res_q.last) begin
            state_d = ST_IDLE;
          end else begin
            inj_d   = search_tok;
            state_d = ST_SCAN;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      tick_q      <= '0;
      sw_q        <= 1'b0;
      inj_q       <= '0;
      out_valid_q <= 1'b0;
      res_q       <= '0;
      out_q       <= '0;
    end else begin
      state_q     <= state_d;
      tick_q      <= tick_d;
      sw_q        <= sw_d;
      inj_q       <= inj_d;
      out_valid_q <= out_valid_d;
      res_q       <= res_d;
      out_q       <= out_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign tick_o      = tick_q;
  assign inj_o       = inj_q;

  a_inj_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inj_q.act |-> state_q == ST_SCAN)
    else $error("token injected outside a scan");

  a_chain_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chain_i.act |-> state_q == ST_SCAN)
    else $error("token left the row outside a scan");

  a_tick_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tick_q >= $past(tick_q))
    else $error("tick count went backwards");

  a_last_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && out_free && res_q.last) |=> state_q == ST_IDLE)
    else $error("no return to idle after the closing result");

endmodule

`default_nettype wire

// ===== rtl/software_timer_queue.sv =====
`default_nettype none

// channel   direction  valid        stall        payload
// in        input      in_valid_i   in_stall_o   in_data_i  (in_t)
// out       output     out_valid_o  out_stall_i  out_data_o (out_t)
// config    input      psel/penable/pwrite/pready, paddr, pwdata, prdata
//
// an add is one token pass along the row of cells followed by a load of the
// output register
// a tick runs one search per expired or re-armed timer plus a closing search;
// each search is one full pass of the row
// reset zeroes the tick count and all slot valid bits, presets task registers
// output stalls hold the controller in its emit step; a new transaction is
// taken while the closing result still waits in the output register

module software_timer_queue
  import sti_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  in_t                in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output out_t               out_data_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  logic signed [TAG_W-1:0] task_tag_q;
  logic [PERIOD_W-1:0]     task_period_q;
  logic [TICK_W-1:0]       tick;
  cmd_t                    cmd;
  token_t                  chain [ENTRIES+1];
  logic                    reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      task_tag_q    <= TASK_TAG_RST;
      task_period_q <= TASK_PERIOD_RST;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_sel)
        REG_TASK_TAG:    task_tag_q    <= pwdata;
        REG_TASK_PERIOD: task_period_q <= pwdata[PERIOD_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_TASK_TAG:    prdata = task_tag_q;
      REG_TASK_PERIOD: prdata = {{(PDATA_W-PERIOD_W){1'b0}}, task_period_q};
    endcase
  end

  sti_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .in_data_i     (in_data_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_data_o    (out_data_o),
    .task_tag_i    (task_tag_q),
    .task_period_i (task_period_q),
    .tick_o        (tick),
    .inj_o         (chain[0]),
    .chain_i       (chain[ENTRIES]),
    .cmd_o         (cmd)
  );

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    sti_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cell_idx_i (IDX_W'(g)),
      .tick_i     (tick),
      .cmd_i      (cmd),
      .tok_i      (chain[g]),
      .tok_o      (chain[g+1])
    );
  end

endmodule

`default_nettype wire
